// File: design/websocket_frame_delimiter_defines.svh
// Assertion macros shared by the frame delimiter RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef WEBSOCKET_FRAME_DELIMITER_DEFINES_SVH
`define WEBSOCKET_FRAME_DELIMITER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define WFD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wfd check failed");

// Next-cycle implication, disabled while in reset
`define WFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wfd check failed");

`endif

// File: design/wfd_pkg.sv
// Types and codes for the frame delimiter.
// No dependencies; imported by websocket_frame_delimiter.
`timescale 1ns / 1ps

package wfd_pkg;

    // Frame part codes, also the parser phase
    localparam logic [2:0] PART_FIRST   = 3'd0;
    localparam logic [2:0] PART_LEN     = 3'd1;
    localparam logic [2:0] PART_EXT     = 3'd2;
    localparam logic [2:0] PART_KEY     = 3'd3;
    localparam logic [2:0] PART_PAYLOAD = 3'd4;

    // Length byte codes
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // Byte counts of the header parts
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [2:0] KEY_BYTES   = 3'd4;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       flush;
    } wfd_in_t;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [2:0]  part;
        logic        frame_last;
        logic [63:0] payload_length;
        logic [3:0]  header_size;
    } wfd_out_t;

endpackage

// File: design/websocket_frame_delimiter.sv
// An accepted item passes through the input register, then the result register.
// Throughput: one byte per cycle, stalled while the result register is full and not read.
// The 64-bit payload countdown sets the critical path.
// A flush item passes through the input register and gives no result.
// Reset (rst_n, async, active low) returns the parser to the first header byte
// and empties both registers.
`timescale 1ns / 1ps

`include "websocket_frame_delimiter_defines.svh"

module websocket_frame_delimiter
    import wfd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  wfd_in_t  item,
    output logic     result_valid,
    input  logic     result_ready,
    output wfd_out_t result
);

    // Input register
    logic    s1_valid_reg;
    wfd_in_t s1_item_reg;
    logic    s1_take;

    // Result register
    logic     res_valid_reg;
    wfd_out_t res_reg;
    wfd_out_t res_next;

    // Parser state
    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  ext_reg, ext_next;
    logic [2:0]  key_reg, key_next;
    logic        masked_reg, masked_next;
    logic [63:0] accum_reg, accum_next;
    logic [63:0] left_reg, left_next;
    logic [3:0]  hcount_reg, hcount_next;

    logic [7:0]  b;
    logic [6:0]  len7;
    logic [2:0]  cur;
    logic        last;

    // Handshake: input register drains when the result register can take the item, or when it holds a flush
    assign s1_take    = s1_valid_reg && (s1_item_reg.flush || !res_valid_reg || result_ready);
    assign item_ready = !s1_valid_reg || s1_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_valid && item_ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_take)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            s1_item_reg <= item;
        end
    end

    // Per-byte header parse and payload countdown; a flush item resets the parser
    always_comb
    begin
        b           = s1_item_reg.rx_byte;
        len7        = b[6:0];
        cur         = phase_reg;
        last        = 1'b0;
        phase_next  = phase_reg;
        ext_next    = ext_reg;
        key_next    = key_reg;
        masked_next = masked_reg;
        accum_next  = accum_reg;
        left_next   = left_reg;
        hcount_next = hcount_reg;

        if (s1_item_reg.flush)
        begin
            phase_next  = PART_FIRST;
            ext_next    = '0;
            key_next    = '0;
            masked_next = 1'b0;
            accum_next  = '0;
            left_next   = '0;
            hcount_next = '0;
        end
        else
        begin
            unique case (phase_reg)
                PART_LEN:
                begin
                    masked_next = b[7];
                    hcount_next = 4'd2;
                    accum_next  = '0;
                    if (len7 == LEN_EXT16)
                    begin
                        ext_next   = EXT16_BYTES;
                        phase_next = PART_EXT;
                    end
                    else if (len7 == LEN_EXT64)
                    begin
                        ext_next   = EXT64_BYTES;
                        phase_next = PART_EXT;
                    end
                    else
                    begin
                        accum_next = {57'd0, len7};
                        // length known
                        if (b[7])
                        begin
                            key_next   = KEY_BYTES;
                            phase_next = PART_KEY;
                        end
                        else if (len7 == 7'd0)
                        begin
                            phase_next = PART_FIRST;
                            last       = 1'b1;
                        end
                        else
                        begin
                            left_next  = {57'd0, len7};
                            phase_next = PART_PAYLOAD;
                        end
                    end
                end
                PART_EXT:
                begin
                    accum_next  = {accum_reg[55:0], b};
                    hcount_next = hcount_reg + 4'd1;
                    ext_next    = ext_reg - 4'd1;
                    if (ext_next == 4'd0)
                    begin
                        if (masked_reg)
                        begin
                            key_next   = KEY_BYTES;
                            phase_next = PART_KEY;
                        end
                        else if (accum_next == 64'd0)
                        begin
                            phase_next = PART_FIRST;
                            last       = 1'b1;
                        end
                        else
                        begin
                            left_next  = accum_next;
                            phase_next = PART_PAYLOAD;
                        end
                    end
                end
                PART_KEY:
                begin
                    hcount_next = hcount_reg + 4'd1;
                    key_next    = key_reg - 3'd1;
                    if (key_next == 3'd0)
                    begin
                        if (accum_reg == 64'd0)
                        begin
                            phase_next = PART_FIRST;
                            last       = 1'b1;
                        end
                        else
                        begin
                            left_next  = accum_reg;
                            phase_next = PART_PAYLOAD;
                        end
                    end
                end
                PART_PAYLOAD:
                begin
                    left_next = left_reg - 64'd1;
                    if (left_reg == 64'd1)
                    begin
                        phase_next = PART_FIRST;
                        last       = 1'b1;
                    end
                end
                default:
                begin
                    // first header byte, or an unused phase code
                    cur         = PART_FIRST;
                    hcount_next = 4'd1;
                    masked_next = 1'b0;
                    accum_next  = '0;
                    left_next   = '0;
                    ext_next    = '0;
                    key_next    = '0;
                    phase_next  = PART_LEN;
                end
            endcase
        end

        res_next.byte_out       = b;
        res_next.part           = cur;
        res_next.frame_last     = last;
        res_next.payload_length = last ? accum_next : 64'd0;
        res_next.header_size    = last ? hcount_next : 4'd0;
    end

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PART_FIRST;
            ext_reg    <= '0;
            key_reg    <= '0;
            masked_reg <= 1'b0;
            accum_reg  <= '0;
            left_reg   <= '0;
            hcount_reg <= '0;
        end
        else if (s1_take)
        begin
            phase_reg  <= phase_next;
            ext_reg    <= ext_next;
            key_reg    <= key_next;
            masked_reg <= masked_next;
            accum_reg  <= accum_next;
            left_reg   <= left_next;
            hcount_reg <= hcount_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_take && !s1_item_reg.flush)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take && !s1_item_reg.flush)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // Checks
    `WFD_ASSERT_SAME(a_key_needs_mask, clk, rst_n, phase_reg == PART_KEY, masked_reg)
    `WFD_ASSERT_SAME(a_payload_nonzero, clk, rst_n, phase_reg == PART_PAYLOAD, left_reg != 64'd0)
    `WFD_ASSERT_SAME(a_mid_frame_zero, clk, rst_n, res_valid_reg && !res_reg.frame_last,
        res_reg.payload_length == 64'd0 && res_reg.header_size == 4'd0)
    `WFD_ASSERT_NEXT(a_take_gives_result, clk, rst_n, s1_take && !s1_item_reg.flush,
        res_valid_reg)

endmodule
